/* rtl/edt_pkg.sv */
// Shared types and constants for the espresso dispense timer.
package edt_pkg;

    // Configuration register indexes.
    localparam logic CFG_SINGLE_TIME = 1'b0;
    localparam logic CFG_DOUBLE_TIME = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Reset values of the shot times, in milliseconds.
    localparam int SINGLE_TIME_RESET = 25000;
    localparam int DOUBLE_TIME_RESET = 45000;

    localparam int SHOT_COUNT_W = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 24;

    // One result item; pump_on sits in the lowest bit.
    typedef struct packed {
        logic [SHOT_COUNT_W-1:0] shot_count;
        logic                    double_chosen;
        logic                    busy_res;
        logic                    pump_on;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

/* rtl/espresso_dispense_timer.sv */
// Top level of the one-button espresso pump timer.
//
//  channel   direction  tdata fields (lowest bit up)
//  s_*       in         button_level[0], zero padding to 8 bits
//  m_*       out        pump_on[0], busy_res[1], double_chosen[2], shot_count[18:3],
//                       zero padding to 24 bits
//  i_cfg_*   in         index 0 single_time_ms, index 1 double_time_ms
//
// Every input transfer is one millisecond tick. The whole update of the timer
// state is combinational, and its result lands in the output register at the
// same edge, so one tick is taken in every cycle while the output side takes
// results. The single output register sets the stall behavior: a new tick is
// accepted when that register is empty or is being emptied in the same cycle.
// Reset is synchronous and active low; it returns the timer to idle with the
// default shot times loaded.
module espresso_dispense_timer #(
    parameter int QUALIFY_MS = 100,
    parameter int LOCKOUT_MS = 500,
    parameter int TIME_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Tick channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [edt_pkg::IN_TDATA_W-1:0]    s_tdata,   // button_level, padding
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [edt_pkg::OUT_TDATA_W-1:0]   m_tdata,   // pump_on, busy_res,
                                                         // double_chosen, shot_count
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [edt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [edt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Elapsed time has one bit more than the shot times and saturates.
    localparam int ELAPSED_W = TIME_WIDTH + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_QUALIFY,
        PH_DISPENSE
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [ELAPSED_W-1:0]            r_elapsed, n_elapsed;
    logic [TIME_WIDTH-1:0]           r_deadline, n_deadline;
    logic                            r_released, n_released;
    logic                            r_double, n_double;
    logic [edt_pkg::SHOT_COUNT_W-1:0] r_shots, n_shots;
    logic                            r_prev_level;

    logic [TIME_WIDTH-1:0]           r_single_time;
    logic [TIME_WIDTH-1:0]           r_double_time;

    logic                            r_m_tvalid;
    edt_pkg::t_result                r_result, n_result;

    logic                            level;
    logic                            in_xfer;
    logic                            past_qualify;
    logic                            in_lockout;
    logic                            past_deadline;

    assign level    = s_tdata[0];
    assign s_tready = !r_m_tvalid || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {{(edt_pkg::OUT_TDATA_W - edt_pkg::RESULT_W){1'b0}}, r_result};

    // Comparisons use the already advanced elapsed time. Qualify and lockout are
    // compared at 32 bits so a window longer than the elapsed range never closes.
    assign past_qualify  = 32'(n_elapsed) >= 32'(QUALIFY_MS);
    assign in_lockout    = 32'(n_elapsed) < 32'(LOCKOUT_MS);
    assign past_deadline = n_elapsed >= ELAPSED_W'(r_deadline);

    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_deadline = r_deadline;
        n_released = r_released;
        n_double   = r_double;
        n_shots    = r_shots;

        if (r_phase != PH_IDLE && r_elapsed != {ELAPSED_W{1'b1}}) begin
            n_elapsed = r_elapsed + 1'b1;
        end

        case (r_phase)
            PH_IDLE: begin
                // A rising edge marks time zero of a new shot.
                if (level && !r_prev_level) begin
                    n_phase    = PH_QUALIFY;
                    n_elapsed  = '0;
                    n_released = 1'b0;
                    n_double   = 1'b0;
                end
            end
            PH_QUALIFY: begin
                if (past_qualify) begin
                    n_phase    = PH_DISPENSE;
                    n_shots    = r_shots + 1'b1;
                    n_deadline = r_single_time;
                end else if (!level) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DISPENSE: begin
                if (in_lockout) begin
                    if (!level) begin
                        n_released = 1'b1;
                    end
                end else if (past_deadline) begin
                    n_phase = PH_IDLE;
                end else if (!r_double) begin
                    // A release and then a new press upgrades to a double shot.
                    if (!r_released) begin
                        if (!level) begin
                            n_released = 1'b1;
                        end
                    end else if (level) begin
                        n_shots    = r_shots + 1'b1;
                        n_double   = 1'b1;
                        n_deadline = r_double_time;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_result.pump_on       = (n_phase == PH_DISPENSE);
        n_result.busy_res      = (n_phase != PH_IDLE);
        n_result.double_chosen = n_double;
        n_result.shot_count    = n_shots;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_elapsed     <= '0;
            r_deadline    <= '0;
            r_released    <= 1'b0;
            r_double      <= 1'b0;
            r_shots       <= '0;
            r_prev_level  <= 1'b0;
            r_single_time <= TIME_WIDTH'(edt_pkg::SINGLE_TIME_RESET);
            r_double_time <= TIME_WIDTH'(edt_pkg::DOUBLE_TIME_RESET);
            r_m_tvalid    <= 1'b0;
        end else begin
            // New times are picked up at the next qualify end or upgrade.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    edt_pkg::CFG_SINGLE_TIME: r_single_time <= TIME_WIDTH'(i_cfg_data);
                    edt_pkg::CFG_DOUBLE_TIME: r_double_time <= TIME_WIDTH'(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            if (in_xfer) begin
                r_phase      <= n_phase;
                r_elapsed    <= n_elapsed;
                r_deadline   <= n_deadline;
                r_released   <= n_released;
                r_double     <= n_double;
                r_shots      <= n_shots;
                r_prev_level <= level;
                r_result     <= n_result;
                r_m_tvalid   <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid   <= 1'b0;
            end
        end
    end

endmodule
